[sv/dto_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dto_pkg: shared types and constants for the definite-time overcurrent block
// Register map, field widths and the structs passed between the modules.
// ----------------------------------------------------------------------------
package dto_pkg;

    localparam int MAG_W    = 16;
    localparam int DELTA_W  = 24;
    localparam int DIAL_W   = 32;
    localparam int NUM_CH   = 3;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_PICKUP_LEVEL = 2'd0;
    localparam logic [1:0] REG_TIME_DIAL    = 2'd1;
    localparam logic [1:0] REG_MODE_NEUTRAL = 2'd2;

    localparam logic [MAG_W-1:0]  PICKUP_LEVEL_RST = 16'hFFFF;
    localparam logic [DIAL_W-1:0] TIME_DIAL_RST    = 32'd100000;

    typedef struct packed {
        logic [MAG_W-1:0]  pickup_level;
        logic [DIAL_W-1:0] time_dial_us;
        logic              mode_neutral;
    } t_cfg;

    typedef struct packed {
        logic pickup;
        logic trip;
        logic changed;
    } t_ch_status;

endpackage

[sv/dto_apb_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dto_apb_regs: configuration register file
// APB-style write and read of pickup level, time dial and mode.
// ----------------------------------------------------------------------------
module dto_apb_regs import dto_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pickup_level <= PICKUP_LEVEL_RST;
            r_cfg.time_dial_us <= TIME_DIAL_RST;
            r_cfg.mode_neutral <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PICKUP_LEVEL: r_cfg.pickup_level <= pwdata[MAG_W-1:0];
                REG_TIME_DIAL:    r_cfg.time_dial_us <= pwdata[DIAL_W-1:0];
                REG_MODE_NEUTRAL: r_cfg.mode_neutral <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PICKUP_LEVEL: prdata = {{(PDATA_W-MAG_W){1'b0}}, r_cfg.pickup_level};
            REG_TIME_DIAL:    prdata = r_cfg.time_dial_us;
            REG_MODE_NEUTRAL: prdata = {{(PDATA_W-1){1'b0}}, r_cfg.mode_neutral};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[sv/dto_channel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dto_channel: one protection channel
// Holds the saturating overcurrent timer and the pickup and trip flags.
// ----------------------------------------------------------------------------
module dto_channel import dto_pkg::*; #(
    parameter int TIMER_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic                   i_active,
    input  logic [MAG_W-1:0]       i_mag,
    input  logic [MAG_W-1:0]       i_level,
    input  logic [DELTA_W-1:0]     i_delta,
    input  logic [DIAL_W-1:0]      i_dial,
    output t_ch_status             o_status,
    output logic [TIMER_WIDTH-1:0] o_timer
);

    localparam int SUM_W = ((TIMER_WIDTH > DELTA_W) ? TIMER_WIDTH : DELTA_W) + 1;
    localparam int CMP_W = ((TIMER_WIDTH > DIAL_W) ? TIMER_WIDTH : DIAL_W) + 1;

    logic [TIMER_WIDTH-1:0] r_timer;
    logic                   r_pick;
    logic                   r_trip;
    logic [TIMER_WIDTH-1:0] n_timer;
    logic                   n_pick;
    logic                   n_trip;
    logic                   over;
    logic [SUM_W-1:0]       sum;
    logic [TIMER_WIDTH-1:0] sat;

    always_comb begin
        over = i_active && (i_mag > i_level);
        sum  = {{(SUM_W-TIMER_WIDTH){1'b0}}, r_timer} + {{(SUM_W-DELTA_W){1'b0}}, i_delta};
        // stop at full scale rather than wrap
        sat  = (|sum[SUM_W-1:TIMER_WIDTH]) ? {TIMER_WIDTH{1'b1}} : sum[TIMER_WIDTH-1:0];
        n_timer = over ? sat : '0;
        n_pick  = over;
        n_trip  = over && (r_trip || ({{(CMP_W-TIMER_WIDTH){1'b0}}, sat} >
                                      {{(CMP_W-DIAL_W){1'b0}}, i_dial}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_pick  <= 1'b0;
            r_trip  <= 1'b0;
        end else if (i_step) begin
            r_timer <= n_timer;
            r_pick  <= n_pick;
            r_trip  <= n_trip;
        end
    end

    assign o_status.pickup  = n_pick;
    assign o_status.trip    = n_trip;
    assign o_status.changed = (n_pick != r_pick) || (n_trip != r_trip);
    assign o_timer          = n_timer;

endmodule

[sv/definite_time_overcurrent.sv]
`timescale 1ns / 1ps
// Pipeline: the input register takes a beat at the accepting edge and hands
//   it to the result register once that register is empty or its beat is
//   being taken, so a result stream held off stalls the input side.
// Throughput: one beat per cycle while results are taken; the single-pass
//   update of the three channel timers between the two registers sets that rate.
// Reset (i_rst_n low, synchronous): timers, flags and both pipeline stages
//   clear; registers return to pickup 65535, dial 100000 us, phase mode.
// ----------------------------------------------------------------------------
// definite_time_overcurrent: definite-time overcurrent protection block
// Three phase channels or one neutral channel, each with a saturating timer;
// reports combined pickup and trip, flag changes and time left to trip.
// ----------------------------------------------------------------------------
module definite_time_overcurrent import dto_pkg::*; #(
    parameter int TIMER_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // mag_a[15:0], mag_b[31:16], mag_c[47:32], mag_n[63:48], delta_us[87:64]
    input  logic [87:0]        s_axis_tdata,
    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // pickup_any[0], trip_any[1], changed[2], pickup_mask[5:3],
    // remaining_us[37:6], zero fill [39:38]
    output logic [39:0]        m_axis_tdata
);

    localparam int CMP_W = ((TIMER_WIDTH > DIAL_W) ? TIMER_WIDTH : DIAL_W) + 1;

    t_cfg cfg;

    dto_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ---------------- input register ----------------
    logic               r_in_valid;
    logic [87:0]        r_in_data;
    logic               advance;
    logic               in_beat;

    // Advance the input register into the result register whenever the
    // result register is empty or its beat is being taken this cycle.
    assign advance       = r_in_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_data <= s_axis_tdata;
        end
    end

    // ---------------- channels ----------------
    logic [MAG_W-1:0]       ch_mag    [NUM_CH];
    logic [NUM_CH-1:0]      ch_active;
    t_ch_status             ch_status [NUM_CH];
    logic [TIMER_WIDTH-1:0] ch_timer  [NUM_CH];
    logic [DELTA_W-1:0]     delta;

    assign delta = r_in_data[87:64];

    // In neutral mode channel 0 follows the neutral magnitude and the other
    // two are held cleared on every beat.
    always_comb begin
        ch_mag[0] = cfg.mode_neutral ? r_in_data[63:48] : r_in_data[15:0];
        ch_mag[1] = r_in_data[31:16];
        ch_mag[2] = r_in_data[47:32];
        ch_active = cfg.mode_neutral ? 3'b001 : 3'b111;
    end

    for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
        dto_channel #(.TIMER_WIDTH(TIMER_WIDTH)) u_ch (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (advance),
            .i_active (ch_active[g]),
            .i_mag    (ch_mag[g]),
            .i_level  (cfg.pickup_level),
            .i_delta  (delta),
            .i_dial   (cfg.time_dial_us),
            .o_status (ch_status[g]),
            .o_timer  (ch_timer[g])
        );
    end

    // ---------------- combine ----------------
    logic [NUM_CH-1:0]      pick_mask;
    logic [NUM_CH-1:0]      trip_mask;
    logic                   any_change;
    logic [TIMER_WIDTH-1:0] min_t;
    logic [CMP_W-1:0]       dial_x;
    logic [CMP_W-1:0]       min_x;
    logic [CMP_W-1:0]       diff;
    logic [DIAL_W-1:0]      remaining;

    always_comb begin
        any_change = 1'b0;
        min_t      = {TIMER_WIDTH{1'b1}};
        for (int k = 0; k < NUM_CH; k++) begin
            pick_mask[k] = ch_status[k].pickup;
            trip_mask[k] = ch_status[k].trip;
            any_change   = any_change || ch_status[k].changed;
            // only picked-up channels compete for the lowest timer value
            if (ch_status[k].pickup && (ch_timer[k] < min_t)) begin
                min_t = ch_timer[k];
            end
        end
        dial_x = {{(CMP_W-DIAL_W){1'b0}}, cfg.time_dial_us};
        min_x  = {{(CMP_W-TIMER_WIDTH){1'b0}}, min_t};
        diff   = dial_x - min_x;
        // floor at zero when nothing is picked up or the dial is reached
        remaining = ((|pick_mask) && (dial_x > min_x)) ? diff[DIAL_W-1:0] : '0;
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (advance) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            m_axis_tdata <= {2'b00, remaining, pick_mask, any_change,
                             |trip_mask, |pick_mask};
        end
    end

endmodule

[tb/sv/tb_definite_time_overcurrent.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_definite_time_overcurrent: self-checking bench for the overcurrent relay
// Streams magnitude beats through the block under random flow control and
// compares every status beat with a cycle-free model of the channel timers,
// pickup and trip flags, kept in step with the register writes.
// ----------------------------------------------------------------------------
module tb_definite_time_overcurrent;
    import dto_pkg::*;

    localparam int TMR_W        = 32;
    localparam int CLK_HALF     = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 200_000;
    // no register lives at this index; writes to it must change nothing
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    // mag_a lands in the lowest bits, delta_us in the highest
    typedef struct packed {
        logic [DELTA_W-1:0] delta_us;
        logic [MAG_W-1:0]   mag_n;
        logic [MAG_W-1:0]   mag_c;
        logic [MAG_W-1:0]   mag_b;
        logic [MAG_W-1:0]   mag_a;
    } mag_beat_t;

    // pickup_any in bit 0, zero fill on top
    typedef struct packed {
        logic [1:0]        fill;
        logic [DIAL_W-1:0] remaining_us;
        logic [2:0]        pickup_mask;
        logic              changed;
        logic              trip_any;
        logic              pickup_any;
    } status_beat_t;

    // ------------------------------------------------------------------------
    // Relay model and status scoreboard
    // ------------------------------------------------------------------------
    class relay_checker;
        logic [MAG_W-1:0]  pickup_level;
        logic [DIAL_W-1:0] time_dial_us;
        logic              mode_neutral;
        logic [TMR_W-1:0]  chan_timer [NUM_CH];
        logic [NUM_CH-1:0] pickup_bits;
        logic [NUM_CH-1:0] trip_bits;
        status_beat_t      status_due_q [$];
        int                bad_beats;

        function new();
            pickup_level = PICKUP_LEVEL_RST;
            time_dial_us = TIME_DIAL_RST;
            mode_neutral = 1'b0;
            foreach (chan_timer[k]) chan_timer[k] = '0;
            pickup_bits  = '0;
            trip_bits    = '0;
            bad_beats    = 0;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
            case (idx)
                REG_PICKUP_LEVEL: pickup_level = val[MAG_W-1:0];
                REG_TIME_DIAL:    time_dial_us = val[DIAL_W-1:0];
                REG_MODE_NEUTRAL: mode_neutral = val[0];
                default: ;
            endcase
        endfunction

        // advance the channel state by one accepted beat and queue its status
        function void note_sample(input mag_beat_t b);
            logic [MAG_W-1:0]  mag [NUM_CH];
            logic [TMR_W:0]    sum;
            logic [TMR_W-1:0]  min_t;
            logic [NUM_CH-1:0] pick, trip;
            bit                have_min;
            int                active;
            status_beat_t      want;

            pick = '0;
            trip = '0;
            min_t = '0;
            have_min = 1'b0;
            if (mode_neutral) begin
                mag[0] = b.mag_n;
                mag[1] = '0;
                mag[2] = '0;
                active = 1;
            end else begin
                mag[0] = b.mag_a;
                mag[1] = b.mag_b;
                mag[2] = b.mag_c;
                active = NUM_CH;
            end
            for (int k = 0; k < NUM_CH; k++) begin
                if (k < active && mag[k] > pickup_level) begin
                    sum = {1'b0, chan_timer[k]} +
                          {{(TMR_W+1-DELTA_W){1'b0}}, b.delta_us};
                    chan_timer[k] = sum[TMR_W] ? '1 : sum[TMR_W-1:0];
                    pick[k] = 1'b1;
                    if (chan_timer[k] > time_dial_us || trip_bits[k])
                        trip[k] = 1'b1;
                    if (!have_min || chan_timer[k] < min_t) begin
                        min_t = chan_timer[k];
                        have_min = 1'b1;
                    end
                end else begin
                    chan_timer[k] = '0;
                end
            end
            want = '0;
            want.changed      = (pick != pickup_bits) || (trip != trip_bits);
            want.pickup_any   = |pick;
            want.trip_any     = |trip;
            want.pickup_mask  = pick;
            want.remaining_us = (have_min && time_dial_us > min_t) ? time_dial_us - min_t : '0;
            pickup_bits = pick;
            trip_bits   = trip;
            status_due_q.push_back(want);
        endfunction

        function void check_status(input status_beat_t got);
            status_beat_t want;
            string        diff;

            if (status_due_q.size() == 0) begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("status beat with nothing outstanding: %h", got);
                return;
            end
            want = status_due_q.pop_front();
            diff = "";
            if (got.pickup_any !== want.pickup_any)     diff = {diff, " pickup_any"};
            if (got.trip_any !== want.trip_any)         diff = {diff, " trip_any"};
            if (got.changed !== want.changed)           diff = {diff, " changed"};
            if (got.pickup_mask !== want.pickup_mask)   diff = {diff, " pickup_mask"};
            if (got.remaining_us !== want.remaining_us) diff = {diff, " remaining_us"};
            if (diff != "") begin
                bad_beats++;
                if (bad_beats <= 10) begin
                    $display("status mismatch:%s", diff);
                    $display("  exp pick=%b trip=%b chg=%b mask=%b rem=%0d",
                             want.pickup_any, want.trip_any, want.changed,
                             want.pickup_mask, want.remaining_us);
                    $display("  got pick=%b trip=%b chg=%b mask=%b rem=%0d",
                             got.pickup_any, got.trip_any, got.changed,
                             got.pickup_mask, got.remaining_us);
                end
            end
        endfunction

        function int pending();
            return status_due_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // mag_a[15:0], mag_b[31:16], mag_c[47:32], mag_n[63:48], delta_us[87:64]
    logic [87:0]         s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // pickup_any[0], trip_any[1], changed[2], pickup_mask[5:3],
    // remaining_us[37:6], zero fill [39:38]
    logic [39:0]         m_axis_tdata;

    // flow-control knobs, written by the stimulus process only
    int src_idle_pct = 6;
    int dst_idle_pct = 56;
    bit hold_req     = 1'b0;

    // receiver-owned hold-off state
    int hold_left  = 0;
    bit hold_taken = 1'b0;

    relay_checker relay = new();

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    definite_time_overcurrent #(
        .TIMER_WIDTH(TMR_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off on request so the
    // pipeline fills and the block has to stall its input side
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Sample handshakes mid-cycle, where every signal has settled for the
    // coming edge; a beat seen here is taken at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            relay.check_status(m_axis_tdata);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one beat, idling at random first; return at the edge that takes it.
    // tvalid stays high on return so back-to-back beats need no second update.
    task automatic push_item(input mag_beat_t b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        relay.note_sample(b);
        @(posedge i_clk);
    endtask

    // Drop tvalid and wait until every queued status beat has come back.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (relay.pending() != 0) @(posedge i_clk);
    endtask

    // Setup then access; the register takes the value at the access edge.
    // The bus is left selected so a following write needs no extra update.
    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        @(posedge i_clk);
        relay.set_reg(idx, val);
    endtask

    // Reprogram the relay while it is idle. Upper bits carry junk, which the
    // block must drop, and the unmapped slot gets a write it must ignore.
    task automatic set_regs(input logic [MAG_W-1:0] pickup, input logic [DIAL_W-1:0] dial,
                            input logic mode);
        settle();
        write_reg(REG_UNMAPPED, $urandom);
        write_reg(REG_PICKUP_LEVEL, {16'($urandom), pickup});
        write_reg(REG_TIME_DIAL, dial);
        write_reg(REG_MODE_NEUTRAL, {31'($urandom), mode});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic mag_beat_t beat_of(input logic [MAG_W-1:0] a, b, c, n,
                                          input logic [DELTA_W-1:0] d);
        mag_beat_t r;
        r.mag_a = a;
        r.mag_b = b;
        r.mag_c = c;
        r.mag_n = n;
        r.delta_us = d;
        return r;
    endfunction

    // A magnitude above or at/below the programmed pickup, leaning on the
    // boundary values now and then.
    function automatic logic [MAG_W-1:0] level_for(input bit hi);
        logic [MAG_W-1:0] lvl;
        int               r;

        lvl = relay.pickup_level;
        r = $urandom_range(99);
        if (hi) begin
            if (lvl == '1) return '1;
            if (r < 10) return lvl + 1'b1;
            return MAG_W'($urandom_range(65535, lvl + 1));
        end
        if (r < 15) return lvl;
        return MAG_W'($urandom_range(lvl, 0));
    endfunction

    // Elapsed time per beat, scaled so a run of len beats tends to cross the dial.
    function automatic logic [DELTA_W-1:0] pick_step(input int len);
        logic [32:0] base;
        int          r;

        r = $urandom_range(99);
        base = 33'(relay.time_dial_us / len);
        base = base * 2 + 1;
        if (base > 33'hFF_FFFF) base = 33'hFF_FFFF;
        if (r < 10) return '0;
        if (r < 20) return '1;
        if (r < 35) return DELTA_W'($urandom);
        return DELTA_W'($urandom_range(base[31:0], 0));
    endfunction

    function automatic mag_beat_t fault_item(input logic [2:0] faulted,
                                             input logic [DELTA_W-1:0] step, input bit noise);
        if (noise)
            return beat_of(MAG_W'($urandom), MAG_W'($urandom), MAG_W'($urandom),
                           MAG_W'($urandom), DELTA_W'($urandom));
        return beat_of(level_for(faulted[0]), level_for(faulted[1]),
                       level_for(faulted[2]), level_for(faulted[0]), step);
    endfunction

    // Fault runs: a random set of channels held above pickup for a while with
    // a steady elapsed time, the rest below; some beats are pure noise.
    task automatic run_fault_bursts(input int n_items);
        int               sent, len;
        logic [2:0]       faulted;
        logic [DELTA_W-1:0] step;

        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(40, 1);
            faulted = 3'($urandom_range(7, 0));
            step = pick_step(len);
            for (int i = 0; i < len && sent < n_items; i++) begin
                push_item(fault_item(faulted, step, $urandom_range(99) < 15));
                sent++;
            end
        end
    endtask

    // One unbroken fault on channel 0 with near-maximum steps, long enough to
    // run its timer into saturation; the other channels drop out now and then.
    task automatic run_long_fault(input int n_items);
        logic [2:0] faulted;

        for (int i = 0; i < n_items; i++) begin
            faulted = {$urandom_range(99) < 80, $urandom_range(99) < 80, 1'b1};
            push_item(fault_item(faulted,
                                 DELTA_W'($urandom_range(24'hFF_FFFF, 24'hE0_0000)),
                                 1'b0));
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: a magnitude equal to the top pickup never picks up.
        push_item(beat_of('1, '1, '1, '1, '1));
        push_item(beat_of('0, '0, '0, '0, '0));

        // Phase channels, pickup 1000, dial 3000 us.
        set_regs(16'd1000, 32'd3000, 1'b0);
        push_item(beat_of(16'd1001, 16'd1000, 16'd0, 16'd0, 24'd1000));   // A just above
        push_item(beat_of(16'd1001, '1, 16'd1000, 16'd0, 24'd2000));       // A lands on dial
        push_item(beat_of(16'd1001, '1, 16'd1000, 16'd0, 24'd1));          // A trips
        push_item(beat_of(16'd1001, '1, 16'd1000, 16'd0, 24'd0));          // nothing moves
        push_item(beat_of(16'd1000, '1, '1, 16'd0, 24'd5000));             // A drops, B/C past dial
        push_item(beat_of(16'd2000, 16'd2000, 16'd2000, 16'd0, 24'd0));    // pickup, zero time
        push_item(beat_of('1, 16'd0, 16'd0, 16'd0, '1));                   // big step on A
        push_item(beat_of(16'd5000, 16'd5000, 16'd5000, 16'd0, 24'd10));   // B and C join

        // Switch to neutral while A is tripped: channel 0 keeps its state,
        // B and C clear and that counts as a change.
        set_regs(16'd1000, 32'd3000, 1'b1);
        push_item(beat_of(16'd0, '1, '1, 16'd5000, 24'd100));
        push_item(beat_of('1, '1, '1, 16'd1000, 24'd100));                 // neutral at level
        push_item(beat_of(16'd0, 16'd0, 16'd0, 16'd1500, 24'd2999));       // one us to go
        push_item(beat_of(16'd0, 16'd0, 16'd0, 16'd1500, 24'd2));          // neutral trips

        // Back to phase mode with channel 0 still tripped.
        set_regs(16'd1000, 32'd3000, 1'b0);
        push_item(beat_of(16'd1500, 16'd0, 16'd0, 16'd0, 24'd0));
        push_item(beat_of(16'd0, 16'd0, 16'd0, 16'd0, 24'd0));

        // Zero pickup and zero dial.
        set_regs(16'd0, 32'd0, 1'b0);
        push_item(beat_of(16'd1, 16'd0, 16'd0, 16'd0, 24'd0));
        push_item(beat_of(16'd1, 16'd0, 16'd0, 16'd0, 24'd1));

        // Random part, sender idling lightly and receiver heavily.
        set_regs(16'd1000, 32'd5000, 1'b0);
        run_fault_bursts(300);
        set_regs(16'd0, 32'd0, 1'b0);
        run_fault_bursts(200);

        // Swap the idling round.
        src_idle_pct = 56;
        dst_idle_pct = 6;
        set_regs(MAG_W'($urandom_range(65535, 0)), $urandom_range(1 << 20, 0), 1'b1);
        run_fault_bursts(300);
        set_regs('1, TIME_DIAL_RST, 1'b0);
        run_fault_bursts(100);

        // No idling; hold the receiver off for a long stretch meanwhile.
        src_idle_pct = 0;
        dst_idle_pct = 0;
        set_regs(16'd200, '1, 1'b0);
        hold_req = 1'b1;
        run_long_fault(320);
        set_regs(16'd40000, 32'hF000_0000, 1'b1);
        run_long_fault(300);
        set_regs(MAG_W'($urandom_range(65535, 0)), $urandom, 1'b0);
        run_fault_bursts(200);

        // Drain, then give any stray beat time to show up.
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (relay.bad_beats == 0 && relay.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("== FAIL ==");
        $finish;
    end

endmodule
